### hw/rtl/gregorian_date_add_days_defines.svh
// ----------------------------------------------------------------------------
// gregorian date add days - assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define GDAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdad same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define GDAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdad next-cycle check failed");

`endif

### hw/rtl/gdad_pkg.sv
// ----------------------------------------------------------------------------
// gdad_pkg
// types, constants and calendar tables for the date add block
// ----------------------------------------------------------------------------
package gdad_pkg;

    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // floor(y / 100) for 14-bit y: (y * 5243) >> 19
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [6:0]  CENT_LAST    = 7'd99;

    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    localparam logic [1:0]  ST_OK       = 2'd0;
    localparam logic [1:0]  ST_INVALID  = 2'd1;
    localparam logic [1:0]  ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [15:0] rem;
        logic [6:0]  r100;
        logic [1:0]  c4;
        logic        invalid;
    } t_job;

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic lp);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2: len = lp ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the months before m, common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] sum;
        case (m)
            4'd1:    sum = 9'd0;
            4'd2:    sum = 9'd31;
            4'd3:    sum = 9'd59;
            4'd4:    sum = 9'd90;
            4'd5:    sum = 9'd120;
            4'd6:    sum = 9'd151;
            4'd7:    sum = 9'd181;
            4'd8:    sum = 9'd212;
            4'd9:    sum = 9'd243;
            4'd10:   sum = 9'd273;
            4'd11:   sum = 9'd304;
            4'd12:   sum = 9'd334;
            default: sum = 9'd0;
        endcase
        return sum;
    endfunction

endpackage

### hw/rtl/gdad_front.sv
// ----------------------------------------------------------------------------
// gdad_front
// takes a request, finds the year's place in its century, checks the start
// date and forms the day count for the month walk
// ----------------------------------------------------------------------------
module gdad_front import gdad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_day,
    input  logic [3:0]  i_month,
    input  logic [13:0] i_year,
    input  logic [14:0] i_add,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_REM, F_PUSH} t_state;

    t_state      r_state;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic [14:0] r_add;
    logic [7:0]  r_q;
    logic [6:0]  r_r100;

    logic [26:0] w_prod;
    logic [14:0] w_q100;
    logic        w_leap;
    logic        w_valid;
    logic        w_adj;
    logic [15:0] w_rem;

    assign w_prod = 27'(r_year) * 27'(DIV100_MUL);
    assign w_q100 = 15'(r_q) * 15'd100;

    assign w_leap = ((r_year[1:0] == 2'd0) && (r_r100 != 7'd0)) ||
                    ((r_r100 == 7'd0) && (r_q[1:0] == 2'd0));

    assign w_valid = (r_month >= 4'd1) && (r_month <= MONTH_DEC) &&
                     (r_year >= 14'd1) && (r_year <= YEAR_MAX) &&
                     (r_day != 5'd0) && (r_day <= days_in(r_month, w_leap));

    assign w_adj = w_leap && (r_month > MONTH_FEB);
    assign w_rem = 16'(r_day) + 16'(days_before(r_month)) + 16'(w_adj) + 16'(r_add);

    assign o_ready     = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);

    always_comb begin
        o_job.day     = r_day;
        o_job.month   = r_month;
        o_job.year    = r_year;
        o_job.rem     = w_rem;
        o_job.r100    = r_r100;
        o_job.c4      = r_q[1:0];
        o_job.invalid = !w_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_day   <= i_day;
                        r_month <= i_month;
                        r_year  <= i_year;
                        r_add   <= i_add;
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    r_q     <= w_prod[DIV100_SHIFT +: 8];
                    r_state <= F_REM;
                end
                F_REM: begin
                    r_r100  <= 7'(r_year - w_q100[13:0]);
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/gdad_queue.sv
// ----------------------------------------------------------------------------
// gdad_queue
// two-entry job queue between the front and the month walk
// ----------------------------------------------------------------------------
module gdad_queue import gdad_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/gdad_walk.sv
// ----------------------------------------------------------------------------
// gdad_walk
// walks month by month from january of the start year, one month a cycle,
// and holds the result until it is taken
// ----------------------------------------------------------------------------
module gdad_walk import gdad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_day,
    output logic [3:0]  o_month,
    output logic [13:0] o_year,
    output logic [1:0]  o_status
);

    typedef enum logic [1:0] {W_IDLE, W_WALK, W_OUT} t_state;

    t_state      r_state;
    logic [4:0]  r_sday;
    logic [3:0]  r_smonth;
    logic [13:0] r_syear;
    logic [15:0] r_rem;
    logic [3:0]  r_cm;
    logic [13:0] r_cy;
    logic [1:0]  r_y4;
    logic [6:0]  r_r100;
    logic [1:0]  r_c4;
    logic        r_valid;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic [1:0]  r_status;

    logic        w_leap;
    logic [4:0]  w_len;
    logic        w_fits;

    assign w_leap = ((r_y4 == 2'd0) && (r_r100 != 7'd0)) ||
                    ((r_r100 == 7'd0) && (r_c4 == 2'd0));
    assign w_len  = days_in(r_cm, w_leap);
    assign w_fits = (r_rem <= 16'(w_len));

    assign o_job_ready = (r_state == W_IDLE);
    assign o_valid     = r_valid;
    assign o_day       = r_day;
    assign o_month     = r_month;
    assign o_year      = r_year;
    assign o_status    = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                W_IDLE: begin
                    if (i_job_valid) begin
                        r_sday   <= i_job.day;
                        r_smonth <= i_job.month;
                        r_syear  <= i_job.year;
                        r_rem    <= i_job.rem;
                        r_cm     <= 4'd1;
                        r_cy     <= i_job.year;
                        r_y4     <= i_job.year[1:0];
                        r_r100   <= i_job.r100;
                        r_c4     <= i_job.c4;
                        if (i_job.invalid) begin
                            r_day    <= i_job.day;
                            r_month  <= i_job.month;
                            r_year   <= i_job.year;
                            r_status <= ST_INVALID;
                            r_valid  <= 1'b1;
                            r_state  <= W_OUT;
                        end else begin
                            r_state <= W_WALK;
                        end
                    end
                end
                W_WALK: begin
                    if (w_fits) begin
                        if (r_cy > YEAR_MAX) begin
                            r_day    <= r_sday;
                            r_month  <= r_smonth;
                            r_year   <= r_syear;
                            r_status <= ST_OVERFLOW;
                        end else begin
                            r_day    <= r_rem[4:0];
                            r_month  <= r_cm;
                            r_year   <= r_cy;
                            r_status <= ST_OK;
                        end
                        r_valid <= 1'b1;
                        r_state <= W_OUT;
                    end else begin
                        r_rem <= r_rem - 16'(w_len);
                        if (r_cm == MONTH_DEC) begin
                            r_cm <= 4'd1;
                            r_cy <= r_cy + 14'd1;
                            r_y4 <= r_y4 + 2'd1;
                            if (r_r100 == CENT_LAST) begin
                                r_r100 <= 7'd0;
                                r_c4   <= r_c4 + 2'd1;
                            end else begin
                                r_r100 <= r_r100 + 7'd1;
                            end
                        end else begin
                            r_cm <= r_cm + 4'd1;
                        end
                    end
                end
                W_OUT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= W_IDLE;
                    end
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/gregorian_date_add_days.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// adds a day count to a gregorian date and returns the resulting date
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request: start day, month, year and the day count.
//   m_axis returns one result per request, in order: end day, month, year
//   in tdata and a status code in tuser (ok, invalid start date, year past
//   9999). on invalid input or year overflow the start date is echoed back.
//   the month walk goes month by month from january of the start year (up to
//   about 1090 months) and retires one month per cycle; this bounds
//   throughput to one request per walk. the front check steps through its
//   idle, divide, remainder and push states for each request and overlaps
//   the walk of the previous one.
//   reset clears all control state; the block then takes a request at once.
//   while the receiver stalls the result stays on m_axis, two more checked
//   requests wait in the queue, one more in the front, then s_axis_tready
//   drops.
// ----------------------------------------------------------------------------
module gregorian_date_add_days import gdad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // start_day, start_month, start_year, days_to_add
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // end_day, end_month, end_year
    output logic [1:0]  m_axis_tuser    // status
);

    t_job       w_front_job;
    t_job       w_queue_job;
    logic       w_front_valid;
    logic       w_queue_ready;
    logic       w_queue_valid;
    logic       w_walk_ready;
    logic [4:0] w_day;
    logic [3:0] w_month;
    logic [13:0] w_year;

    gdad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_day       (s_axis_tdata[4:0]),
        .i_month     (s_axis_tdata[8:5]),
        .i_year      (s_axis_tdata[22:9]),
        .i_add       (s_axis_tdata[37:23]),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_queue_ready),
        .o_job       (w_front_job)
    );

    gdad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .o_ready (w_queue_ready),
        .i_job   (w_front_job),
        .o_valid (w_queue_valid),
        .i_pop   (w_walk_ready),
        .o_job   (w_queue_job)
    );

    gdad_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_queue_valid),
        .o_job_ready (w_walk_ready),
        .i_job       (w_queue_job),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_day       (w_day),
        .o_month     (w_month),
        .o_year      (w_year),
        .o_status    (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, w_year, w_month, w_day};

endmodule

### hw/rtl/gdad_checker.sv
// ----------------------------------------------------------------------------
// gdad_checker
// port-level checks on the result stream of the date add block
// ----------------------------------------------------------------------------
`include "gregorian_date_add_days_defines.svh"

module gdad_checker import gdad_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    `GDAD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)

    `GDAD_ASSERT_IMP(a_status_code, i_clk, i_rst_n, i_m_tvalid, (i_m_tuser == ST_OK) || (i_m_tuser == ST_INVALID) || (i_m_tuser == ST_OVERFLOW))

    `GDAD_ASSERT_IMP(a_ok_month_day, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser == ST_OK), (i_m_tdata[8:5] >= 4'd1) && (i_m_tdata[8:5] <= MONTH_DEC) && (i_m_tdata[4:0] != 5'd0))

    `GDAD_ASSERT_IMP(a_ok_year, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser == ST_OK), (i_m_tdata[22:9] >= 14'd1) && (i_m_tdata[22:9] <= YEAR_MAX))

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for gregorian_date_add_days: drives date requests
// on s_axis with random gaps (none in burst mode), predicts each resulting
// date and status with a calendar walk of its own, and compares every m_axis
// result in order
module tb_top;
    import gdad_pkg::*;

    localparam int unsigned IDLE_PCT     = 31;
    localparam int unsigned STALL_LIMIT  = 20000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned MAX_PRINTED  = 40;

    // fields from the lowest bit up: day, month, year, days to add
    typedef struct packed {
        logic [14:0] add;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_res_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    date_res_t   pending_dates[$];
    int unsigned fail_count;
    int unsigned stall_cycles;
    bit          burst_mode;
    date_res_t   got_date;
    date_res_t   want_date;

    gregorian_date_add_days dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // start_day, start_month, start_year, days_to_add
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // end_day, end_month, end_year
        .m_axis_tuser  (m_axis_tuser)    // status
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit is_leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
        if (mon == MONTH_FEB)
            return is_leap_year(yr) ? 29 : 28;
        if (mon == 4 || mon == 6 || mon == 9 || mon == 11)
            return 30;
        return 31;
    endfunction

    function automatic date_res_t predict_end_date(input date_req_t r);
        date_res_t   res;
        int unsigned doy;
        int unsigned mon;
        int unsigned yr;
        res.day    = r.day;
        res.month  = r.month;
        res.year   = r.year;
        res.status = ST_INVALID;
        if (r.month < 1 || r.month > MONTH_DEC || r.year < 1 || r.year > YEAR_MAX ||
            r.day < 1 || r.day > month_length(r.month, r.year))
            return res;
        doy = r.day;
        for (mon = 1; mon < r.month; mon++)
            doy += month_length(mon, r.year);
        doy += r.add;
        mon = 1;
        yr  = r.year;
        while (doy > month_length(mon, yr)) begin
            doy -= month_length(mon, yr);
            mon++;
            if (mon > MONTH_DEC) begin
                mon = 1;
                yr++;
            end
        end
        if (yr > YEAR_MAX) begin
            res.status = ST_OVERFLOW;
            return res;
        end
        res.day    = doy[4:0];
        res.month  = mon[3:0];
        res.year   = yr[13:0];
        res.status = ST_OK;
        return res;
    endfunction

    function automatic date_req_t make_req(input int unsigned d, input int unsigned m,
                                           input int unsigned y, input int unsigned a);
        date_req_t r;
        r.day   = d[4:0];
        r.month = m[3:0];
        r.year  = y[13:0];
        r.add   = a[14:0];
        return r;
    endfunction

    function automatic int unsigned random_day_count();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return $urandom_range(1000, 0);
        if (pick < 90)
            return $urandom & 32'h7fff;
        return $urandom_range(32767, 32000);
    endfunction

    function automatic date_req_t random_valid_date();
        int unsigned pick;
        int unsigned mon;
        int unsigned yr;
        pick = $urandom_range(99);
        mon  = $urandom_range(12, 1);
        if (pick < 60)
            yr = $urandom_range(YEAR_MAX, 1);
        else if (pick < 75)
            yr = $urandom_range(YEAR_MAX, 9900);
        else if (pick < 88)
            yr = $urandom_range(99, 1) * 100;
        else
            yr = $urandom_range(50, 1);
        return make_req($urandom_range(month_length(mon, yr), 1), mon, yr, random_day_count());
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("mismatch: %s", msg);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input date_req_t r);
        while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pending_dates.push_back(predict_end_date(r));
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n)
            m_axis_tready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", stall_cycles);
                $display("Simulation FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_date = {m_axis_tuser, m_axis_tdata[22:0]};
                if (pending_dates.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d/%0d/%0d status %0d",
                        got_date.day, got_date.month, got_date.year, got_date.status));
                end else begin
                    want_date = pending_dates.pop_front();
                    if (got_date.day !== want_date.day)
                        report_mismatch($sformatf("end_day %0d, want %0d",
                            got_date.day, want_date.day));
                    if (got_date.month !== want_date.month)
                        report_mismatch($sformatf("end_month %0d, want %0d",
                            got_date.month, want_date.month));
                    if (got_date.year !== want_date.year)
                        report_mismatch($sformatf("end_year %0d, want %0d",
                            got_date.year, want_date.year));
                    if (got_date.status !== want_date.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                            got_date.status, want_date.status));
                end
            end
        end
    end

    task automatic test_directed();
        send_request(make_req(1, 1, 1, 0));
        send_request(make_req(31, 12, 9999, 0));
        send_request(make_req(31, 12, 9999, 1));
        send_request(make_req(1, 1, 1, 32767));
        send_request(make_req(31, 12, 1, 32767));
        send_request(make_req(28, 2, 1900, 1));
        send_request(make_req(28, 2, 2000, 1));
        send_request(make_req(29, 2, 2004, 365));
        send_request(make_req(29, 2, 2000, 0));
        send_request(make_req(29, 2, 1900, 0));
        send_request(make_req(30, 2, 2000, 0));
        send_request(make_req(0, 5, 2020, 10));
        send_request(make_req(31, 4, 2021, 1));
        send_request(make_req(1, 0, 2021, 1));
        send_request(make_req(1, 13, 2021, 1));
        send_request(make_req(1, 15, 2021, 1));
        send_request(make_req(1, 1, 0, 1));
        send_request(make_req(1, 1, 10000, 1));
        send_request(make_req(31, 15, 16383, 32767));
        send_request(make_req(31, 12, 9910, 32767));
        send_request(make_req(1, 1, 9999, 364));
        send_request(make_req(1, 1, 9999, 365));
        send_request(make_req(31, 1, 2023, 29));
        send_request(make_req(31, 12, 2399, 60));
    endtask

    task automatic test_random_valid(input int unsigned count);
        repeat (count) send_request(random_valid_date());
    endtask

    task automatic test_invalid_dates(input int unsigned count);
        date_req_t   r;
        int unsigned len;
        repeat (count) begin
            if ($urandom_range(1)) begin
                r.day   = 5'($urandom);
                r.month = 4'($urandom);
                r.year  = 14'($urandom);
                r.add   = 15'($urandom);
            end else begin
                r   = random_valid_date();
                len = month_length(r.month, r.year);
                if (len == 31 || $urandom_range(3) == 0)
                    r.day = 5'd0;
                else
                    r.day = 5'($urandom_range(31, len + 1));
            end
            send_request(r);
        end
    endtask

    task automatic test_back_to_back(input int unsigned count);
        date_req_t r;
        burst_mode = 1'b1;
        repeat (count) begin
            r     = random_valid_date();
            r.add = 15'($urandom_range(400, 0));
            send_request(r);
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        fail_count    = 0;
        stall_cycles  = 0;
        burst_mode    = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_valid(380);
        test_invalid_dates(76);
        test_back_to_back(60);

        s_axis_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### gregorian_date_add_days.f
+incdir+hw/rtl
hw/rtl/gdad_pkg.sv
hw/rtl/gdad_front.sv
hw/rtl/gdad_queue.sv
hw/rtl/gdad_walk.sv
hw/rtl/gregorian_date_add_days.sv
hw/rtl/gdad_checker.sv
tb/tb_top.sv
